/* rtl/core/rxs_pkg.sv */
// Shared types, constants and the sequencer microprogram of the record sort block.
package rxs_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int TAG_BITS_DEF    = 16;
    localparam int KEY_W           = 32;
    localparam int OUT_TAG_W       = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ILOAD,
        ST_ILATCH,
        ST_JREAD,
        ST_JCMP,
        ST_IWRITE,
        ST_EINIT,
        ST_EREAD,
        ST_EOUT
    } t_step;

    typedef enum logic {
        RD_I,
        RD_J
    } t_rd_sel;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_ACCEPT_FINAL,
        COND_I_DONE,
        COND_J_MORE
    } t_cond;

    typedef struct packed {
        logic    busy;
        logic    load_en;
        t_rd_sel rd_sel;
        logic    latch_a;
        logic    cmp_swap;
        logic    write_i;
        logic    clr_i;
        logic    clr_j;
        logic    emit;
        t_cond   cond;
        t_step   go_true;
        t_step   go_false;
    } t_ctrl;

    typedef struct packed {
        logic accept_final;
        logic i_done;
        logic j_more;
    } t_status;

    // Control store: one word per step.
    function automatic t_ctrl ucode(t_step step);
        t_ctrl c;
        c          = '0;
        c.busy     = 1'b1;
        c.rd_sel   = RD_I;
        c.cond     = COND_ALWAYS;
        c.go_true  = ST_IDLE;
        c.go_false = ST_IDLE;
        unique case (step)
            ST_IDLE: begin
                c.busy     = 1'b0;
                c.load_en  = 1'b1;
                c.clr_i    = 1'b1;
                c.cond     = COND_ACCEPT_FINAL;
                c.go_true  = ST_ILOAD;
                c.go_false = ST_IDLE;
            end
            ST_ILOAD: begin
                c.rd_sel   = RD_I;
                c.go_true  = ST_ILATCH;
                c.go_false = ST_ILATCH;
            end
            ST_ILATCH: begin
                c.latch_a  = 1'b1;
                c.cond     = COND_I_DONE;
                c.go_true  = ST_EINIT;
                c.go_false = ST_JREAD;
            end
            ST_JREAD: begin
                c.rd_sel   = RD_J;
                c.go_true  = ST_JCMP;
                c.go_false = ST_JCMP;
            end
            ST_JCMP: begin
                c.cmp_swap = 1'b1;
                c.cond     = COND_J_MORE;
                c.go_true  = ST_JREAD;
                c.go_false = ST_IWRITE;
            end
            ST_IWRITE: begin
                c.write_i  = 1'b1;
                c.go_true  = ST_ILOAD;
                c.go_false = ST_ILOAD;
            end
            ST_EINIT: begin
                c.clr_j    = 1'b1;
                c.go_true  = ST_EREAD;
                c.go_false = ST_EREAD;
            end
            ST_EREAD: begin
                c.rd_sel   = RD_J;
                c.go_true  = ST_EOUT;
                c.go_false = ST_EOUT;
            end
            ST_EOUT: begin
                c.emit     = 1'b1;
                c.cond     = COND_J_MORE;
                c.go_true  = ST_EREAD;
                c.go_false = ST_IDLE;
            end
            default: begin
                c.go_true  = ST_IDLE;
                c.go_false = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/record_exchange_sort_by_key.sv */
// Record sort top level: loads records, exchange-sorts them by signed key, emits in order.
// Records load at one per cycle while busy is low; the one marked final starts the sort of
// the n stored records (n at most MAX_RECORDS, extras dropped and flagged on every result of
// that run). The sort runs on a single-port-read record memory driven by a microcoded
// sequencer, each compare taking a read step and a compare step, and busy stays high from the
// final record on. Results then appear, each held for one cycle under o_strobe; the
// receiver cannot stall them, and busy falls as the last one is presented.
module record_exchange_sort_by_key #(
    parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF,
    parameter int TAG_BITS    = rxs_pkg::TAG_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [rxs_pkg::KEY_W-1:0]     i_key,
    input  logic        [TAG_BITS-1:0]           i_tag,
    input  logic                                 i_final_record,
    output logic                                 o_strobe,
    output logic signed [rxs_pkg::KEY_W-1:0]     o_sorted_key,
    output logic        [rxs_pkg::OUT_TAG_W-1:0] o_sorted_tag,
    output logic                                 o_end_of_run,
    output logic                                 o_overflowed
);

    rxs_pkg::t_ctrl   ctrl;
    rxs_pkg::t_status status;

    rxs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    rxs_dp #(
        .MAX_RECORDS (MAX_RECORDS),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_start        (start),
        .i_key          (i_key),
        .i_tag          (i_tag),
        .i_final_record (i_final_record),
        .o_status       (status),
        .o_strobe       (o_strobe),
        .o_sorted_key   (o_sorted_key),
        .o_sorted_tag   (o_sorted_tag),
        .o_end_of_run   (o_end_of_run),
        .o_overflowed   (o_overflowed)
    );

    assign busy = ctrl.busy;

endmodule

/* rtl/core/rxs_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module rxs_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rxs_pkg::t_status i_status,
    output rxs_pkg::t_ctrl   o_ctrl
);

    rxs_pkg::t_step r_step;
    rxs_pkg::t_step n_step;
    rxs_pkg::t_ctrl ctrl;
    logic           cond_true;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= rxs_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        ctrl = rxs_pkg::ucode(r_step);
    end

    always_comb begin
        unique case (ctrl.cond)
            rxs_pkg::COND_ALWAYS:       cond_true = 1'b1;
            rxs_pkg::COND_ACCEPT_FINAL: cond_true = i_status.accept_final;
            rxs_pkg::COND_I_DONE:       cond_true = i_status.i_done;
            rxs_pkg::COND_J_MORE:       cond_true = i_status.j_more;
            default:                    cond_true = 1'b1;
        endcase
        n_step = cond_true ? ctrl.go_true : ctrl.go_false;
    end

    assign o_ctrl = ctrl;

endmodule

/* rtl/core/rxs_dp.sv */
// Datapath: record memory, index counters, held record, compare and result registers.
module rxs_dp #(
    parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF,
    parameter int TAG_BITS    = rxs_pkg::TAG_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rxs_pkg::t_ctrl                      i_ctrl,
    input  logic                                i_start,
    input  logic signed [rxs_pkg::KEY_W-1:0]    i_key,
    input  logic        [TAG_BITS-1:0]          i_tag,
    input  logic                                i_final_record,
    output rxs_pkg::t_status                    o_status,
    output logic                                o_strobe,
    output logic signed [rxs_pkg::KEY_W-1:0]    o_sorted_key,
    output logic        [rxs_pkg::OUT_TAG_W-1:0] o_sorted_tag,
    output logic                                o_end_of_run,
    output logic                                o_overflowed
);

    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int ADDR_W = $clog2(MAX_RECORDS);
    localparam int REC_W  = rxs_pkg::KEY_W + TAG_BITS;

    logic [REC_W-1:0] mem [MAX_RECORDS];

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    logic [REC_W-1:0] r_a;
    logic [REC_W-1:0] r_rd;

    logic                             r_strobe;
    logic signed [rxs_pkg::KEY_W-1:0] r_out_key;
    logic [rxs_pkg::OUT_TAG_W-1:0]    r_out_tag;
    logic                             r_out_end;
    logic                             r_out_ovf;

    logic [CNT_W-1:0]  i_inc;
    logic [CNT_W-1:0]  j_inc;
    logic              accept;
    logic              room;
    logic              last_out;
    logic              greater;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [REC_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;

    logic signed [rxs_pkg::KEY_W-1:0]    a_key;
    logic signed [rxs_pkg::KEY_W-1:0]    rd_key;
    logic [TAG_BITS-1:0]                 rd_tag;
    logic [TAG_BITS+rxs_pkg::OUT_TAG_W-1:0] tag_ext;

    assign i_inc    = r_i + CNT_W'(1);
    assign j_inc    = r_j + CNT_W'(1);
    assign room     = r_count < CNT_W'(MAX_RECORDS);
    assign accept   = i_ctrl.load_en & i_start;
    assign a_key    = r_a[REC_W-1:TAG_BITS];
    assign rd_key   = r_rd[REC_W-1:TAG_BITS];
    assign rd_tag   = r_rd[TAG_BITS-1:0];
    assign greater  = a_key > rd_key;
    assign last_out = i_ctrl.emit & ~o_status.j_more;
    assign tag_ext  = {{rxs_pkg::OUT_TAG_W{1'b0}}, rd_tag};

    always_comb begin
        o_status.accept_final = accept & i_final_record;
        o_status.i_done       = i_inc >= r_count;
        o_status.j_more       = j_inc < r_count;
    end

    // Only one write per step: a load in idle, a swap back into slot j, or
    // the settled minimum back into slot i.
    always_comb begin
        we    = 1'b0;
        waddr = r_count[ADDR_W-1:0];
        wdata = {i_key, i_tag};
        if (accept && room) begin
            we = 1'b1;
        end else if (i_ctrl.cmp_swap && greater) begin
            we    = 1'b1;
            waddr = r_j[ADDR_W-1:0];
            wdata = r_a;
        end else if (i_ctrl.write_i) begin
            we    = 1'b1;
            waddr = r_i[ADDR_W-1:0];
            wdata = r_a;
        end
    end

    assign raddr = (i_ctrl.rd_sel == rxs_pkg::RD_I) ? r_i[ADDR_W-1:0] : r_j[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (last_out) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            if (room) begin
                r_count <= r_count + CNT_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else begin
            if (i_ctrl.clr_i) begin
                r_i <= '0;
            end else if (i_ctrl.write_i) begin
                r_i <= i_inc;
            end
            if (i_ctrl.clr_j) begin
                r_j <= '0;
            end else if (i_ctrl.latch_a) begin
                r_j <= i_inc;
            end else if (i_ctrl.cmp_swap || i_ctrl.emit) begin
                r_j <= j_inc;
            end
        end
    end

    // The held record is the current occupant of slot i during its pass.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch_a || (i_ctrl.cmp_swap && greater)) begin
            r_a <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_out_key <= rd_key;
            r_out_tag <= tag_ext[rxs_pkg::OUT_TAG_W-1:0];
            r_out_end <= ~o_status.j_more;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_sorted_key = r_out_key;
    assign o_sorted_tag = r_out_tag;
    assign o_end_of_run = r_out_end;
    assign o_overflowed = r_out_ovf;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("record count exceeds capacity");

    a_end_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out_end) |-> (r_count == '0 && !r_ovf))
        else $error("store not emptied after the last result");

    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.cmp_swap |-> (r_j > r_i && r_j < r_count))
        else $error("compare index out of order");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.emit |-> r_j < r_count)
        else $error("emitting beyond stored records");

endmodule

/* sim/record_exchange_sort_by_key_tb.sv */
// Self-checking testbench for the record exchange sort block: drives record sets, checks sorted runs.
`timescale 1ns / 100ps

module record_exchange_sort_by_key_tb;

    localparam int KW    = rxs_pkg::KEY_W;
    localparam int TW    = rxs_pkg::TAG_BITS_DEF;
    localparam int OTW   = rxs_pkg::OUT_TAG_W;
    localparam int DEPTH = rxs_pkg::MAX_RECORDS_DEF;

    localparam logic signed [KW-1:0] KEY_MIN = {1'b1, {(KW-1){1'b0}}};
    localparam logic signed [KW-1:0] KEY_MAX = {1'b0, {(KW-1){1'b1}}};

    typedef struct {
        logic signed [KW-1:0] key;
        logic [OTW-1:0]       tag;
        logic                 last;
        logic                 ovf;
    } sorted_rec_t;

    class sorted_run_board;
        logic signed [KW-1:0] key_mem [DEPTH];
        logic [TW-1:0]        tag_mem [DEPTH];
        int unsigned          stored;
        bit                   dropped;
        sorted_rec_t          pending_sorted [$];
        int unsigned          errors;

        function new();
            stored  = 0;
            dropped = 0;
            errors  = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Ascending exchange sort over the stored records, swapping on strict greater-than.
        function void sort_stored();
            logic signed [KW-1:0] tk;
            logic [TW-1:0]        tt;
            for (int i = 0; i < stored; i++) begin
                for (int j = i + 1; j < stored; j++) begin
                    if (key_mem[i] > key_mem[j]) begin
                        tk = key_mem[i];
                        tt = tag_mem[i];
                        key_mem[i] = key_mem[j];
                        tag_mem[i] = tag_mem[j];
                        key_mem[j] = tk;
                        tag_mem[j] = tt;
                    end
                end
            end
        endfunction

        function void note_record(input logic signed [KW-1:0] key, input logic [TW-1:0] tag,
                                  input logic fin);
            sorted_rec_t r;
            if (stored < DEPTH) begin
                key_mem[stored] = key;
                tag_mem[stored] = tag;
                stored++;
            end else begin
                dropped = 1'b1;
            end
            if (fin) begin
                sort_stored();
                for (int k = 0; k < stored; k++) begin
                    r.key  = key_mem[k];
                    r.tag  = OTW'(tag_mem[k]);
                    r.last = (k + 1 == stored);
                    r.ovf  = dropped;
                    pending_sorted.push_back(r);
                end
                stored  = 0;
                dropped = 1'b0;
            end
        endfunction

        task check_result(input logic signed [KW-1:0] key, input logic [OTW-1:0] tag,
                          input logic last, input logic ovf);
            sorted_rec_t r;
            if (pending_sorted.size() == 0) begin
                report($sformatf("unexpected result key=%0d tag=%h", key, tag));
            end else begin
                r = pending_sorted.pop_front();
                if (key !== r.key)
                    report($sformatf("sorted_key %0d, expected %0d", key, r.key));
                if (tag !== r.tag)
                    report($sformatf("sorted_tag %h, expected %h", tag, r.tag));
                if (last !== r.last)
                    report($sformatf("end_of_run %b, expected %b", last, r.last));
                if (ovf !== r.ovf)
                    report($sformatf("overflowed %b, expected %b", ovf, r.ovf));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [KW-1:0] i_key;
    logic [TW-1:0]        i_tag;
    logic                 i_final_record;
    logic                 o_strobe;
    logic signed [KW-1:0] o_sorted_key;
    logic [OTW-1:0]       o_sorted_tag;
    logic                 o_end_of_run;
    logic                 o_overflowed;

    sorted_run_board board;
    int unsigned     records_sent;

    record_exchange_sort_by_key i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_key          (i_key),
        .i_tag          (i_tag),
        .i_final_record (i_final_record),
        .o_strobe       (o_strobe),
        .o_sorted_key   (o_sorted_key),
        .o_sorted_tag   (o_sorted_tag),
        .o_end_of_run   (o_end_of_run),
        .o_overflowed   (o_overflowed)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Mix of wide random keys, a narrow band that forces ties, and the extremes.
    function automatic logic signed [KW-1:0] draw_key();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $urandom;
        else if (pick < 8)
            return $signed($urandom_range(0, 8)) - 4;
        else begin
            case ($urandom_range(0, 5))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return KEY_MIN + 1;
                3: return KEY_MAX - 1;
                4: return '0;
                default: return '1;
            endcase
        end
    endfunction

    task send_record(input logic signed [KW-1:0] key, input logic [TW-1:0] tag,
                     input logic fin, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_key          <= key;
        i_tag          <= tag;
        i_final_record <= fin;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        board.note_record(key, tag, fin);
        records_sent++;
    endtask

    // One record set of n items; a burst set has no gaps between items.
    task send_set(input int n, input bit burst);
        for (int k = 0; k < n; k++)
            send_record(draw_key(), TW'($urandom), k == n - 1,
                        burst ? 0 : $urandom_range(0, 15));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_result(o_sorted_key, o_sorted_tag, o_end_of_run, o_overflowed);
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int n;
        board          = new();
        records_sent   = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_key          = '0;
        i_tag          = '0;
        i_final_record = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A set of one record.
        send_record(KEY_MAX, 16'hFFFF, 1'b1, 0);
        // Extremes of key and tag.
        send_record(KEY_MIN, 16'h0000, 1'b0, 0);
        send_record(KEY_MAX, 16'hFFFF, 1'b0, 3);
        send_record('0, 16'h1234, 1'b0, 0);
        send_record('1, 16'h8001, 1'b1, 1);
        // Ties: the exchange pattern decides where equal keys land.
        send_record(5, 16'h0001, 1'b0, 0);
        send_record(5, 16'h0002, 1'b0, 0);
        send_record(3, 16'h0003, 1'b0, 2);
        send_record(5, 16'h0004, 1'b0, 0);
        send_record(3, 16'h0005, 1'b1, 0);
        // Strictly descending input.
        send_record(KEY_MAX, 16'h00A0, 1'b0, 0);
        send_record(1, 16'h00A1, 1'b0, 0);
        send_record(0, 16'h00A2, 1'b0, 0);
        send_record(-1, 16'h00A3, 1'b0, 0);
        send_record(KEY_MIN, 16'h00A4, 1'b1, 0);
        // Alternating bit patterns.
        send_record(32'sh5555_5555, 16'h5555, 1'b0, 0);
        send_record(32'shAAAA_AAAA, 16'hAAAA, 1'b1, 0);

        // Exactly full, then a final record dropped on a full store, then plain overflow.
        send_set(DEPTH, 1'b1);
        send_set(DEPTH + 1, $urandom_range(0, 1));
        send_set($urandom_range(DEPTH + 2, DEPTH + 8), $urandom_range(0, 1));

        while (records_sent < 450) begin
            if ($urandom_range(0, 15) == 0)
                n = $urandom_range(30, DEPTH + 6);
            else
                n = $urandom_range(1, 12);
            send_set(n, $urandom_range(0, 3) == 0);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending_sorted.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (board.errors == 0 && board.stored == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/rxs_pkg.sv
rtl/core/rxs_seq.sv
rtl/core/rxs_dp.sv
rtl/core/record_exchange_sort_by_key.sv
sim/record_exchange_sort_by_key_tb.sv
